FILE: sv/imu_fp_pkg.sv
`default_nettype none

package imu_fp_pkg;

   // Frame header and length limits.
   localparam logic [7:0] HDR_FIRST  = 8'h7E;
   localparam logic [7:0] HDR_SECOND = 8'h23;
   localparam logic [7:0] LEN_MIN    = 8'd5;
   localparam logic [7:0] LEN_MAX    = 8'd64;

   // Reset values of the function code registers.
   localparam logic [7:0] EULER_CODE_RST  = 8'h26;
   localparam logic [7:0] MOTION_CODE_RST = 8'h04;

   // Configuration register indexes.
   localparam logic CSR_EULER_CODE  = 1'b0;
   localparam logic CSR_MOTION_CODE = 1'b1;

   // Byte counter codes with a meaning of their own; higher counts are payload.
   localparam logic [5:0] CNT_HUNT = 6'd0;
   localparam logic [5:0] CNT_HDR2 = 6'd1;
   localparam logic [5:0] CNT_LEN  = 6'd2;

   // Only frame positions 3 (function code) through 21 (last motion byte)
   // are ever read back, so only those are kept.
   localparam int STORE_LO = 3;
   localparam int STORE_HI = 21;

   // Frame kind codes.
   localparam logic KIND_EULER  = 1'b0;
   localparam logic KIND_MOTION = 1'b1;

   typedef logic [STORE_HI:STORE_LO][7:0] store_type;

   typedef struct packed {
      logic valid;
      logic kind;
   } hit_type;

endpackage

`default_nettype wire

FILE: sv/imu_fp_track.sv
`default_nettype none

module imu_fp_track (
   input  wire logic                clock,
   input  wire logic                reset,
   input  wire logic                req_valid,
   output logic                     req_ready,
   input  wire logic [7:0]          rx_byte,
   input  wire logic [7:0]          euler_code,
   input  wire logic [7:0]          motion_code,
   input  wire logic                hit_take,
   output imu_fp_pkg::hit_type      hit,
   output imu_fp_pkg::store_type    store
);

   logic [5:0]              cnt_ff, cnt_in;
   logic [6:0]              len_ff, len_in;
   logic [7:0]              sum_ff, sum_in;
   imu_fp_pkg::store_type   store_ff, store_in;
   imu_fp_pkg::hit_type     hit_ff, hit_in;
   logic [6:0]              cnt_inc;
   logic [7:0]              code;
   logic                    accept;

   // A pending hit blocks new bytes: the next frame would overwrite the store.
   assign req_ready = !hit_ff.valid || hit_take;
   assign accept    = req_valid && req_ready;
   assign code      = store_ff[imu_fp_pkg::STORE_LO];
   assign cnt_inc   = {1'b0, cnt_ff} + 7'd1;

   always_comb begin
      cnt_in   = cnt_ff;
      len_in   = len_ff;
      sum_in   = sum_ff;
      store_in = store_ff;
      hit_in   = hit_ff;
      if (hit_take) begin
         hit_in.valid = 1'b0;
      end
      if (accept) begin
         if (cnt_ff >= 6'(imu_fp_pkg::STORE_LO) && cnt_ff <= 6'(imu_fp_pkg::STORE_HI)) begin
            store_in[cnt_ff[4:0]] = rx_byte;
         end
         case (cnt_ff)
            imu_fp_pkg::CNT_HUNT: begin
               if (rx_byte == imu_fp_pkg::HDR_FIRST) begin
                  cnt_in = imu_fp_pkg::CNT_HDR2;
                  sum_in = rx_byte;
               end
            end
            imu_fp_pkg::CNT_HDR2: begin
               if (rx_byte != imu_fp_pkg::HDR_SECOND) begin
                  cnt_in = imu_fp_pkg::CNT_HUNT;
               end else begin
                  cnt_in = imu_fp_pkg::CNT_LEN;
                  sum_in = sum_ff + rx_byte;
               end
            end
            imu_fp_pkg::CNT_LEN: begin
               if (rx_byte < imu_fp_pkg::LEN_MIN || rx_byte > imu_fp_pkg::LEN_MAX) begin
                  cnt_in = imu_fp_pkg::CNT_HUNT;
               end else begin
                  cnt_in = cnt_inc[5:0];
                  len_in = rx_byte[6:0];
                  sum_in = sum_ff + rx_byte;
               end
            end
            default: begin
               if (cnt_inc == len_ff) begin
                  // Last byte of the frame: it is the checksum.
                  cnt_in = imu_fp_pkg::CNT_HUNT;
                  if (sum_ff == rx_byte && (code == euler_code || code == motion_code)) begin
                     hit_in.valid = 1'b1;
                     hit_in.kind  = (code == euler_code) ? imu_fp_pkg::KIND_EULER
                                                          : imu_fp_pkg::KIND_MOTION;
                  end
               end else begin
                  cnt_in = cnt_inc[5:0];
                  sum_in = sum_ff + rx_byte;
               end
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff   <= imu_fp_pkg::CNT_HUNT;
         len_ff   <= '0;
         sum_ff   <= '0;
         store_ff <= '0;
         hit_ff   <= '0;
      end else begin
         cnt_ff   <= cnt_in;
         len_ff   <= len_in;
         sum_ff   <= sum_in;
         store_ff <= store_in;
         hit_ff   <= hit_in;
      end
   end

   assign hit   = hit_ff;
   assign store = store_ff;

   // A hit that is not taken stays, with its kind.
   assert property (@(posedge clock) disable iff (reset)
      hit_ff.valid && !hit_take |=> hit_ff.valid && $stable(hit_ff.kind))
      else $error("pending hit lost or changed");

   // A hit only appears right after a byte was taken.
   assert property (@(posedge clock) disable iff (reset)
      $rose(hit_ff.valid) |-> $past(accept))
      else $error("hit without a byte");

   // Inside a frame body the count stays below a legal length.
   assert property (@(posedge clock) disable iff (reset)
      cnt_ff > imu_fp_pkg::CNT_LEN |-> len_ff >= 7'd5 && len_ff <= 7'd64 && {1'b0, cnt_ff} < len_ff)
      else $error("byte count outside frame");

endmodule

`default_nettype wire

FILE: sv/imu_fp_decode.sv
`default_nettype none

module imu_fp_decode (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire imu_fp_pkg::hit_type   hit,
   input  wire imu_fp_pkg::store_type store,
   output logic                       hit_take,
   output logic                       rsp_valid,
   input  wire logic                  rsp_ready,
   output logic                       rsp_frame_kind,
   output logic signed [31:0]         rsp_value_0,
   output logic signed [31:0]         rsp_value_1,
   output logic signed [31:0]         rsp_value_2,
   output logic signed [15:0]         rsp_value_3,
   output logic signed [15:0]         rsp_value_4,
   output logic signed [15:0]         rsp_value_5,
   output logic signed [15:0]         rsp_value_6,
   output logic signed [15:0]         rsp_value_7,
   output logic signed [15:0]         rsp_value_8
);

   logic                valid_ff, valid_in;
   logic                kind_ff;
   logic signed [31:0]  wide_ff [3];
   logic signed [15:0]  narrow_ff [6];
   logic signed [31:0]  wide_in [3];
   logic signed [15:0]  narrow_in [6];
   logic                euler;

   assign hit_take = hit.valid && (!valid_ff || rsp_ready);
   assign valid_in = hit_take || (valid_ff && !rsp_ready);
   assign euler    = (hit.kind == imu_fp_pkg::KIND_EULER);

   always_comb begin
      if (euler) begin
         wide_in[0] = {store[7], store[6], store[5], store[4]};
         wide_in[1] = {store[11], store[10], store[9], store[8]};
         wide_in[2] = {store[15], store[14], store[13], store[12]};
         for (int k = 0; k < 6; k++) begin
            narrow_in[k] = '0;
         end
      end else begin
         wide_in[0] = {{16{store[5][7]}}, store[5], store[4]};
         wide_in[1] = {{16{store[7][7]}}, store[7], store[6]};
         wide_in[2] = {{16{store[9][7]}}, store[9], store[8]};
         narrow_in[0] = {store[11], store[10]};
         narrow_in[1] = {store[13], store[12]};
         narrow_in[2] = {store[15], store[14]};
         narrow_in[3] = {store[17], store[16]};
         narrow_in[4] = {store[19], store[18]};
         narrow_in[5] = {store[21], store[20]};
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (hit_take) begin
         kind_ff   <= hit.kind;
         wide_ff   <= wide_in;
         narrow_ff <= narrow_in;
      end
   end

   assign rsp_valid      = valid_ff;
   assign rsp_frame_kind = kind_ff;
   assign rsp_value_0    = wide_ff[0];
   assign rsp_value_1    = wide_ff[1];
   assign rsp_value_2    = wide_ff[2];
   assign rsp_value_3    = narrow_ff[0];
   assign rsp_value_4    = narrow_ff[1];
   assign rsp_value_5    = narrow_ff[2];
   assign rsp_value_6    = narrow_ff[3];
   assign rsp_value_7    = narrow_ff[4];
   assign rsp_value_8    = narrow_ff[5];

   // Taking a hit always leaves a result waiting.
   assert property (@(posedge clock) disable iff (reset)
      hit_take |=> valid_ff)
      else $error("hit taken but no result");

   // Euler results carry zero samples in the short fields.
   assert property (@(posedge clock) disable iff (reset)
      valid_ff && kind_ff == imu_fp_pkg::KIND_EULER |-> narrow_ff[0] == '0 && narrow_ff[5] == '0)
      else $error("euler result with nonzero sample fields");

endmodule

`default_nettype wire

FILE: sv/imu_frame_parser.sv
// The checksum byte sets the hit register; the result register then holds the item.
// Throughput: one byte item per cycle; a finished frame needs at least five bytes.
// The byte side stalls only while a finished frame waits behind an unread result.
// Reset (synchronous, active high) clears the frame store, byte count, checksum,
// pending result and loads function codes 0x26 (euler) and 0x04 (motion).
`default_nettype none

module imu_frame_parser (
   input  wire logic               clock,
   input  wire logic               reset,
   // Byte input channel.
   input  wire logic               req_valid,
   output logic                    req_ready,
   input  wire logic [7:0]         req_rx_byte,
   // Decoded frame channel.
   output logic                    rsp_valid,
   input  wire logic               rsp_ready,
   output logic                    rsp_frame_kind,
   output logic signed [31:0]      rsp_value_0,
   output logic signed [31:0]      rsp_value_1,
   output logic signed [31:0]      rsp_value_2,
   output logic signed [15:0]      rsp_value_3,
   output logic signed [15:0]      rsp_value_4,
   output logic signed [15:0]      rsp_value_5,
   output logic signed [15:0]      rsp_value_6,
   output logic signed [15:0]      rsp_value_7,
   output logic signed [15:0]      rsp_value_8,
   // Configuration write port.
   input  wire logic               csr_we,
   input  wire logic               csr_index,
   input  wire logic [7:0]         csr_wdata
);

   logic [7:0]              euler_code_ff, euler_code_in;
   logic [7:0]              motion_code_ff, motion_code_in;
   imu_fp_pkg::hit_type     hit;
   imu_fp_pkg::store_type   store;
   logic                    hit_take;

   // The user writes code registers only while the parser is idle; not enforced.
   always_comb begin
      euler_code_in  = euler_code_ff;
      motion_code_in = motion_code_ff;
      if (csr_we) begin
         case (csr_index)
            imu_fp_pkg::CSR_EULER_CODE:  euler_code_in  = csr_wdata;
            imu_fp_pkg::CSR_MOTION_CODE: motion_code_in = csr_wdata;
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         euler_code_ff  <= imu_fp_pkg::EULER_CODE_RST;
         motion_code_ff <= imu_fp_pkg::MOTION_CODE_RST;
      end else begin
         euler_code_ff  <= euler_code_in;
         motion_code_ff <= motion_code_in;
      end
   end

   // The tracker follows the header, length and running checksum byte by byte,
   // keeps the payload positions that decoding reads, and flags a frame whose
   // checksum and function code are good. The store keeps older contents past
   // the end of a short frame, so such fields come from earlier frames.
   imu_fp_track u_track (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_ready   (req_ready),
      .rx_byte     (req_rx_byte),
      .euler_code  (euler_code_ff),
      .motion_code (motion_code_ff),
      .hit_take    (hit_take),
      .hit         (hit),
      .store       (store)
   );

   // The decoder picks the little-endian fields out of the store when it takes
   // the hit and holds them in the result register until taken. No byte lands
   // in the store in between: the tracker holds off bytes until the hit is taken.
   imu_fp_decode u_decode (
      .clock          (clock),
      .reset          (reset),
      .hit            (hit),
      .store          (store),
      .hit_take       (hit_take),
      .rsp_valid      (rsp_valid),
      .rsp_ready      (rsp_ready),
      .rsp_frame_kind (rsp_frame_kind),
      .rsp_value_0    (rsp_value_0),
      .rsp_value_1    (rsp_value_1),
      .rsp_value_2    (rsp_value_2),
      .rsp_value_3    (rsp_value_3),
      .rsp_value_4    (rsp_value_4),
      .rsp_value_5    (rsp_value_5),
      .rsp_value_6    (rsp_value_6),
      .rsp_value_7    (rsp_value_7),
      .rsp_value_8    (rsp_value_8)
   );

endmodule

`default_nettype wire
